### sv/sapq_pkg.sv
// Shared types and codes for the sorted-array priority queue.
// No dependencies; every other file imports this package.
package sapq_pkg;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_DELETE  = 2'd1;
    localparam logic [1:0] MODE_READOUT = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] item;
        logic [3:0]         count;
        logic               last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_ROTATE
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

endpackage

### sv/sapq_cell.sv
// One storage cell of the sorted chain: a value, its valid flag and the
// local compare. Depends on sapq_pkg.
module sapq_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sapq_pkg::t_cmd               i_cmd,
    input  logic signed [VALUE_BITS-1:0] i_key,
    input  logic signed [VALUE_BITS-1:0] i_head,
    input  logic signed [VALUE_BITS-1:0] i_prev_value,
    input  logic                         i_prev_valid,
    input  logic                         i_prev_take,
    input  logic signed [VALUE_BITS-1:0] i_next_value,
    input  logic                         i_next_valid,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic                         o_valid,
    output logic                         o_take,
    output logic                         o_match
);
    import sapq_pkg::*;

    logic signed [VALUE_BITS-1:0] r_value, n_value;
    logic                         r_valid, n_valid;

    // Take marks this cell and everything behind it: key is not smaller.
    assign o_take  = !r_valid || (i_key >= r_value);
    assign o_match = r_valid && (i_key == r_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        case (i_cmd)
            CMD_INSERT: begin
                if (o_take) begin
                    n_value = i_prev_take ? i_prev_value : i_key;
                    n_valid = i_prev_take ? i_prev_valid : 1'b1;
                end
            end
            CMD_DELETE: begin
                if (o_take) begin
                    n_value = i_next_value;
                    n_valid = i_next_valid;
                end
            end
            CMD_ROTATE: begin
                // Last occupied cell wraps the head around.
                if (r_valid) begin
                    n_value = i_next_valid ? i_next_value : i_head;
                end
            end
            default: begin
                n_value = r_value;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

### sv/sorted_array_priority_queue_top.sv
// Top level of the sorted-array priority queue: control sequencer,
// output register and the chain of sapq_cell instances. Depends on sapq_pkg.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_data) carries one item with a
//   mode and a value. Output channel (o_out_valid, i_out_stall, o_out_data)
//   carries result items with status, item, count and last.
//   Insert and delete update the chain in the cycle the item is accepted;
//   their single result is registered and shows on the output the cycle after.
//   A new insert or delete can be taken every cycle while the output keeps
//   draining, so throughput is one item per cycle for those modes.
//   Readout of N stored values streams N results, one per cycle while the
//   receiver does not stall, via the stream state and the output register;
//   the chain rotates one place per result and is back in order after the
//   last one. The input is stalled during the stream.
//   An empty readout or delete, a delete of an absent value, an insert into
//   a full store and the unused mode each give one result with last set.
//   The rotation step of the chain sets the readout rate.
//   Reset clears the valid flags of all cells, the fill count, the sequencer
//   and the output valid flag. Cell values are not reset.
//   When the receiver stalls, the result held in the output register stays
//   put, the readout stream pauses and no new input item is taken.
module sorted_array_priority_queue_top #(
    parameter int DEPTH      = 8,
    parameter int VALUE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sapq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sapq_pkg::t_out_item o_out_data
);
    import sapq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Chain wiring
    logic signed [VALUE_BITS-1:0] w_value [DEPTH];
    logic [DEPTH-1:0]             w_valid;
    logic [DEPTH-1:0]             w_take;
    logic [DEPTH-1:0]             w_match;
    logic signed [VALUE_BITS-1:0] w_key;
    logic signed [15:0]           w_head_item;
    logic                         w_found;

    t_state     r_state, n_state;
    logic [CNT_W-1:0] r_held, n_held;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;
    t_cmd       w_cmd;
    logic       w_out_free;
    logic       w_in_acc;
    logic       w_stream_last;

    // Fold the 16-bit input value into the stored width.
    generate
        if (VALUE_BITS <= 16) begin : g_key_narrow
            assign w_key = i_in_data.value[VALUE_BITS-1:0];
        end else begin : g_key_wide
            assign w_key = {{(VALUE_BITS - 16){1'b0}}, i_in_data.value};
        end
        if (VALUE_BITS >= 16) begin : g_item_wide
            assign w_head_item = w_value[0][15:0];
        end else begin : g_item_narrow
            assign w_head_item = {{(16 - VALUE_BITS){1'b0}}, w_value[0]};
        end
    endgenerate

    assign w_found = |w_match;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [VALUE_BITS-1:0] w_prev_value;
            logic                         w_prev_valid;
            logic                         w_prev_take;
            logic signed [VALUE_BITS-1:0] w_next_value;
            logic                         w_next_valid;

            if (gi == 0) begin : g_first
                assign w_prev_value = w_key;
                assign w_prev_valid = 1'b0;
                assign w_prev_take  = 1'b0;
            end else begin : g_mid
                assign w_prev_value = w_value[gi-1];
                assign w_prev_valid = w_valid[gi-1];
                assign w_prev_take  = w_take[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_next_value = w_value[gi];
                assign w_next_valid = 1'b0;
            end else begin : g_body
                assign w_next_value = w_value[gi+1];
                assign w_next_valid = w_valid[gi+1];
            end

            sapq_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_key       (w_key),
                .i_head      (w_value[0]),
                .i_prev_value(w_prev_value),
                .i_prev_valid(w_prev_valid),
                .i_prev_take (w_prev_take),
                .i_next_value(w_next_value),
                .i_next_valid(w_next_valid),
                .o_value     (w_value[gi]),
                .o_valid     (w_valid[gi]),
                .o_take      (w_take[gi]),
                .o_match     (w_match[gi])
            );
        end
    endgenerate

    // Handshake: take input only when idle and the output slot frees up.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !w_out_free;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_stream_last = ({{(CNT_W){1'b0}}, r_idx} + (CNT_W + IDX_W)'(1))
                           == (CNT_W + IDX_W)'(r_held);

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_cmd       = CMD_HOLD;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid   = 1'b1;
                    n_out.status  = STATUS_OK;
                    n_out.item    = '0;
                    n_out.last    = 1'b1;
                    case (i_in_data.mode)
                        MODE_INSERT: begin
                            if (r_held >= CNT_W'(DEPTH)) begin
                                n_out.status = STATUS_FULL;
                            end else begin
                                w_cmd  = CMD_INSERT;
                                n_held = r_held + CNT_W'(1);
                            end
                        end
                        MODE_DELETE: begin
                            if (r_held == '0) begin
                                n_out.status = STATUS_EMPTY;
                            end else if (!w_found) begin
                                n_out.status = STATUS_NOT_FOUND;
                            end else begin
                                w_cmd  = CMD_DELETE;
                                n_held = r_held - CNT_W'(1);
                            end
                        end
                        MODE_READOUT: begin
                            if (r_held == '0) begin
                                n_out.status = STATUS_EMPTY;
                            end else begin
                                // Hold off the result; the stream starts next cycle.
                                n_out_valid = 1'b0;
                                n_state     = ST_STREAM;
                                n_idx       = '0;
                            end
                        end
                        default: begin
                            n_out.status = STATUS_OK;
                        end
                    endcase
                    n_out.count = 4'(n_held);
                end
            end
            ST_STREAM: begin
                if (w_out_free) begin
                    // Emit the head, rotate the chain by one place.
                    w_cmd        = CMD_ROTATE;
                    n_out_valid  = 1'b1;
                    n_out.status = STATUS_OK;
                    n_out.item   = w_head_item;
                    n_out.count  = 4'(r_held);
                    n_out.last   = w_stream_last;
                    if (w_stream_last) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule
